[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/hwsc_pkg.sv]
// ----------------------------------------------------------------------------
// hwsc_pkg
// Shared constants, types and codes for the head window height span check.
// ----------------------------------------------------------------------------
`default_nettype none

package hwsc_pkg;

    localparam int MAX_ROW_POINTS = 256;
    localparam int HEIGHT_W       = 16;
    localparam int CFG_W          = 14;
    localparam int CNT_W          = $clog2(MAX_ROW_POINTS + 1);
    localparam int SUM_W          = HEIGHT_W + CNT_W;
    localparam int DIV_STEP_W     = $clog2(SUM_W);
    localparam int LIMIT_W        = HEIGHT_W + 2;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [PADDR_W-1:0] ADDR_DEPTH_MARGIN = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_SPAN_LIMIT   = 3'd4;

    localparam logic [CFG_W-1:0] DEPTH_MARGIN_RST = 14'd250;
    localparam logic [CFG_W-1:0] SPAN_LIMIT_RST   = 14'd350;

    localparam logic signed [HEIGHT_W-1:0] MEAN_MOST_POS = 16'sh7FFF;
    localparam logic signed [HEIGHT_W-1:0] MEAN_MOST_NEG = 16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [HEIGHT_W-1:0] mean;
    } div_rsp_t;

endpackage

`default_nettype wire

[rtl/hwsc_div.sv]
// ----------------------------------------------------------------------------
// hwsc_div
// Radix-2 restoring divider: signed row sum over unsigned point count,
// truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hwsc_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hwsc_pkg::div_req_t req,
    output hwsc_pkg::div_rsp_t      rsp
);
    import hwsc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      dvs_reg;
    logic [SUM_W-1:0]      dvd_reg;
    logic [HEIGHT_W-1:0]   mean_reg;

    logic [SUM_W-1:0]      sum_mag;
    logic [CNT_W:0]        shifted;
    logic [CNT_W+1:0]      diff;
    logic                  ge;
    logic [CNT_W-1:0]      rem_next;
    logic [SUM_W-1:0]      quo_next;
    logic [SUM_W-1:0]      quo_neg;

    always_comb begin
        sum_mag  = req.sum[SUM_W-1] ? (~req.sum + 1'b1) : req.sum;
        shifted  = {rem_reg, dvd_reg[SUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dvs_reg};
        ge       = !diff[CNT_W+1];
        rem_next = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo_next = {dvd_reg[SUM_W-2:0], ge};
        quo_neg  = ~quo_next + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg  <= req.sum[SUM_W-1];
            dvs_reg  <= req.count;
            dvd_reg  <= sum_mag;
            rem_reg  <= '0;
            step_reg <= DIV_STEP_W'(SUM_W - 1);
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            dvd_reg  <= quo_next;
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0) begin
                mean_reg <= neg_reg ? quo_neg[HEIGHT_W-1:0] : quo_next[HEIGHT_W-1:0];
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.mean = mean_reg;

    `ASSERT_IMPLIES(a_start_when_free, aclk, aresetn, req.start, !busy_reg && !done_reg)
    `ASSERT_NEXT(a_done_after_last, aclk, aresetn, busy_reg && step_reg == '0 && !req.start,
                 done_reg && !busy_reg)

endmodule

`default_nettype wire

[rtl/head_window_height_span_check.sv]
// ----------------------------------------------------------------------------
// head_window_height_span_check
// Row-mean height span test over the depth points of one candidate window.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one depth point per transaction, with row_end / window_end
//   flags. A point is counted if valid, nearer than center_depth plus
//   depth_margin, and its row holds fewer than MAX_ROW_POINTS counted points.
//   m_* carries one result per window: is_head and height_span.
//   A point without a row or window end passes accept (ST_IDLE) and the close
//   check (ST_CLOSE). Closing a non-empty row adds a pass through the shared
//   divider, which forms one quotient bit per cycle over the row sum width.
//   A window end adds a finish step to form the result, then the result sits
//   in the output register until taken; s_ready stays low meanwhile, so a
//   stalled receiver holds off the point stream.
//   Reset (aresetn low, synchronous) clears row and window state and loads
//   depth_margin = 250, head_span_limit = 350. Registers are on an APB-style
//   port at byte 0 and 4; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module head_window_height_span_check (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [hwsc_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [hwsc_pkg::PDATA_W-1:0]         pwdata,
    output logic      [hwsc_pkg::PDATA_W-1:0]         prdata,
    output logic                                      pready,
    // point stream
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [hwsc_pkg::HEIGHT_W-1:0] s_point_height,
    input  wire logic signed [hwsc_pkg::HEIGHT_W-1:0] s_point_depth,
    input  wire logic                                 s_point_valid,
    input  wire logic signed [hwsc_pkg::HEIGHT_W-1:0] s_center_depth,
    input  wire logic                                 s_row_end,
    input  wire logic                                 s_window_end,
    // result
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_is_head,
    output logic      [hwsc_pkg::HEIGHT_W-1:0]        m_height_span
);
    import hwsc_pkg::*;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]           depth_margin_reg;
    logic [CFG_W-1:0]           span_limit_reg;
    logic signed [SUM_W-1:0]    row_sum_reg, row_sum_next;
    logic [CNT_W-1:0]           row_count_reg, row_count_next;
    logic signed [HEIGHT_W-1:0] least_reg, least_next;
    logic signed [HEIGHT_W-1:0] greatest_reg, greatest_next;
    logic                       any_row_reg, any_row_next;
    logic                       wend_reg, wend_next;
    logic                       rend_reg, rend_next;
    logic                       is_head_reg, is_head_next;
    logic [HEIGHT_W-1:0]        span_reg, span_next;

    logic                       s_fire;
    logic                       m_fire;
    logic                       cfg_wr;
    logic signed [LIMIT_W-1:0]  near_limit;
    logic                       counted;
    logic [HEIGHT_W:0]          span_full;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_margin_reg <= DEPTH_MARGIN_RST;
            span_limit_reg   <= SPAN_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_DEPTH_MARGIN: depth_margin_reg <= pwdata[CFG_W-1:0];
                ADDR_SPAN_LIMIT:   span_limit_reg   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_DEPTH_MARGIN: prdata = PDATA_W'(depth_margin_reg);
            ADDR_SPAN_LIMIT:   prdata = PDATA_W'(span_limit_reg);
            default:           prdata = '0;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                if ((rend_reg || wend_reg) && row_count_reg != '0) state_next = ST_DIV;
                else if (wend_reg)                                 state_next = ST_FIN;
                else                                               state_next = ST_IDLE;
            end
            ST_DIV: begin
                if (div_rsp.done) state_next = wend_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN: state_next = ST_OUT;
            ST_OUT: begin
                if (m_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        m_valid       = (state_reg == ST_OUT);
        div_req.start = (state_reg == ST_CLOSE) && (rend_reg || wend_reg)
                        && row_count_reg != '0;
        div_req.sum   = row_sum_reg;
        div_req.count = row_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // datapath
    assign near_limit = LIMIT_W'(s_center_depth) + $signed({4'b0000, depth_margin_reg});
    assign counted    = s_point_valid && (LIMIT_W'(s_point_depth) < near_limit)
                        && (row_count_reg < CNT_W'(MAX_ROW_POINTS));
    assign span_full  = {greatest_reg[HEIGHT_W-1], greatest_reg}
                        - {least_reg[HEIGHT_W-1], least_reg};

    always_comb begin
        row_sum_next   = row_sum_reg;
        row_count_next = row_count_reg;
        least_next     = least_reg;
        greatest_next  = greatest_reg;
        any_row_next   = any_row_reg;
        wend_next      = wend_reg;
        rend_next      = rend_reg;
        is_head_next   = is_head_reg;
        span_next      = span_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    wend_next = s_window_end;
                    rend_next = s_row_end;
                    if (counted) begin
                        row_sum_next   = row_sum_reg + SUM_W'(s_point_height);
                        row_count_next = row_count_reg + 1'b1;
                    end
                end
            end
            ST_CLOSE: begin
                // divider has latched the row, so the row can be cleared now
                if (rend_reg || wend_reg) begin
                    row_sum_next   = '0;
                    row_count_next = '0;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.mean < least_reg)    least_next    = div_rsp.mean;
                    if (div_rsp.mean > greatest_reg) greatest_next = div_rsp.mean;
                    any_row_next = 1'b1;
                end
            end
            ST_FIN: begin
                span_next     = any_row_reg ? span_full[HEIGHT_W-1:0] : '0;
                is_head_next  = (any_row_reg ? span_full[HEIGHT_W-1:0] : '0)
                                <= HEIGHT_W'(span_limit_reg);
                least_next    = MEAN_MOST_POS;
                greatest_next = MEAN_MOST_NEG;
                any_row_next  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_sum_reg   <= '0;
            row_count_reg <= '0;
            least_reg     <= MEAN_MOST_POS;
            greatest_reg  <= MEAN_MOST_NEG;
            any_row_reg   <= 1'b0;
            wend_reg      <= 1'b0;
            rend_reg      <= 1'b0;
        end else begin
            row_sum_reg   <= row_sum_next;
            row_count_reg <= row_count_next;
            least_reg     <= least_next;
            greatest_reg  <= greatest_next;
            any_row_reg   <= any_row_next;
            wend_reg      <= wend_next;
            rend_reg      <= rend_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_head_reg <= is_head_next;
        span_reg    <= span_next;
    end

    assign m_is_head     = is_head_reg;
    assign m_height_span = span_reg;

    hwsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    `ASSERT_IMPLIES(a_no_accept_with_result, aclk, aresetn, m_valid, !s_ready)
    `ASSERT_IMPLIES(a_done_only_in_div, aclk, aresetn, div_rsp.done, state_reg == ST_DIV)
    `ASSERT_NEXT(a_start_enters_div, aclk, aresetn, div_req.start, state_reg == ST_DIV)
    `ASSERT_NEXT(a_window_cleared, aclk, aresetn, state_reg == ST_FIN,
                 !any_row_reg && row_count_reg == '0)

endmodule

`default_nettype wire
